@@ hw/rtl/ckhm_pkg.sv @@
// Shared types and constants for the 24-hour clock with digit editor.
package ckhm_pkg;

  // Operation codes carried in the input item
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_EDIT  = 3'd2;
  localparam logic [2:0] OP_INC   = 3'd3;
  localparam logic [2:0] OP_DEC   = 3'd4;
  localparam logic [2:0] OP_NEXT  = 3'd5;
  localparam logic [2:0] OP_ACCEPT = 3'd6;

  // Time-of-day limits
  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  // Editor digit positions
  localparam logic [1:0] POS_HOUR_TENS = 2'd0;
  localparam logic [1:0] POS_HOUR_ONES = 2'd1;
  localparam logic [1:0] POS_MIN_TENS  = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_item_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [5:0] seconds_now;
    logic       editing;
    logic [1:0] edit_position;
    logic       blink;
  } out_item_t;

  // Complete clock and editor state
  typedef struct packed {
    logic [5:0]      sec_count;
    logic [5:0]      min_count;
    logic [4:0]      hour_count;
    logic [3:0][3:0] edit_digits;
    logic            edit_active;
    logic [1:0]      digit_select;
    logic            blink_bit;
  } clk_state_t;

endpackage

@@ hw/rtl/ckhm_state.sv @@
// Clock and editor state registers with their per-item update logic.
module ckhm_state (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  ckhm_pkg::in_item_t     item,
  output ckhm_pkg::clk_state_t   state_nxt
);

  ckhm_pkg::clk_state_t state_r;

  // Next state for the item presented
  always_comb begin
    ckhm_pkg::clk_state_t s;
    logic [1:0] pos;
    logic [3:0] modulus;
    logic [3:0] cur;
    logic [4:0] inc_v;
    logic [7:0] hr_sum;
    logic [7:0] mn_sum;
    s   = state_r;
    pos = state_r.digit_select;
    cur = state_r.edit_digits[pos];
    // values the selected digit may take; hour digits limit each other
    case (pos)
      ckhm_pkg::POS_HOUR_TENS: modulus = (state_r.edit_digits[1] >= 4'd4) ? 4'd2 : 4'd3;
      ckhm_pkg::POS_HOUR_ONES: modulus = (state_r.edit_digits[0] == 4'd2) ? 4'd4 : 4'd10;
      ckhm_pkg::POS_MIN_TENS:  modulus = 4'd6;
      default:                 modulus = 4'd10;
    endcase
    inc_v  = {1'b0, cur} + 5'd1;
    hr_sum = {4'd0, state_r.edit_digits[0]} * 8'd10 + {4'd0, state_r.edit_digits[1]};
    mn_sum = {4'd0, state_r.edit_digits[2]} * 8'd10 + {4'd0, state_r.edit_digits[3]};

    case (item.opcode)
      ckhm_pkg::OP_TICK: begin
        if (!state_r.edit_active) begin
          s.blink_bit = ~state_r.blink_bit;
          if (state_r.sec_count < ckhm_pkg::SEC_MAX) begin
            s.sec_count = state_r.sec_count + 6'd1;
          end else begin
            s.sec_count = '0;
            if (state_r.min_count < ckhm_pkg::MIN_MAX) begin
              s.min_count = state_r.min_count + 6'd1;
            end else begin
              s.min_count  = '0;
              s.hour_count = (state_r.hour_count < ckhm_pkg::HOUR_MAX) ?
                             state_r.hour_count + 5'd1 : 5'd0;
            end
          end
        end
      end
      ckhm_pkg::OP_LOAD: begin
        s.hour_count  = (item.load_hour > ckhm_pkg::HOUR_MAX) ?
                        ckhm_pkg::HOUR_MAX : item.load_hour;
        s.min_count   = (item.load_minute > ckhm_pkg::MIN_MAX) ?
                        ckhm_pkg::MIN_MAX : item.load_minute;
        s.sec_count   = (item.load_second > ckhm_pkg::SEC_MAX) ?
                        ckhm_pkg::SEC_MAX : item.load_second;
        s.edit_active = 1'b0;
      end
      ckhm_pkg::OP_EDIT: begin
        s.edit_digits  = '0;
        s.digit_select = ckhm_pkg::POS_HOUR_TENS;
        s.edit_active  = 1'b1;
      end
      ckhm_pkg::OP_INC: begin
        if (state_r.edit_active) begin
          s.edit_digits[pos] = (inc_v >= {1'b0, modulus}) ?
                               4'(inc_v - {1'b0, modulus}) : inc_v[3:0];
        end
      end
      ckhm_pkg::OP_DEC: begin
        if (state_r.edit_active) begin
          s.edit_digits[pos] = (cur == 4'd0) ? modulus - 4'd1 : cur - 4'd1;
        end
      end
      ckhm_pkg::OP_NEXT: begin
        if (state_r.edit_active) begin
          s.digit_select = state_r.digit_select + 2'd1;
        end
      end
      ckhm_pkg::OP_ACCEPT: begin
        if (state_r.edit_active) begin
          s.hour_count  = (hr_sum > {3'd0, ckhm_pkg::HOUR_MAX}) ?
                          ckhm_pkg::HOUR_MAX : hr_sum[4:0];
          s.min_count   = (mn_sum > {2'd0, ckhm_pkg::MIN_MAX}) ?
                          ckhm_pkg::MIN_MAX : mn_sum[5:0];
          s.sec_count   = '0;
          s.edit_active = 1'b0;
        end
      end
      default: begin
        s = state_r;
      end
    endcase
    state_nxt = s;
  end

  // State register, advanced once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/ckhm_disp.sv @@
// Maps the clock state to the displayed digits and status of a result item.
module ckhm_disp (
  input  ckhm_pkg::clk_state_t state,
  output ckhm_pkg::out_item_t  item
);

  logic [1:0] hr_tens;
  logic [4:0] hr_rem;
  logic [2:0] mn_tens;
  logic [5:0] mn_rem;

  // Hour split into decimal digits
  always_comb begin
    if (state.hour_count >= 5'd20) begin
      hr_tens = 2'd2;
      hr_rem  = state.hour_count - 5'd20;
    end else if (state.hour_count >= 5'd10) begin
      hr_tens = 2'd1;
      hr_rem  = state.hour_count - 5'd10;
    end else begin
      hr_tens = 2'd0;
      hr_rem  = state.hour_count;
    end
  end

  // Minute split into decimal digits
  always_comb begin
    if (state.min_count >= 6'd50) begin
      mn_tens = 3'd5;
      mn_rem  = state.min_count - 6'd50;
    end else if (state.min_count >= 6'd40) begin
      mn_tens = 3'd4;
      mn_rem  = state.min_count - 6'd40;
    end else if (state.min_count >= 6'd30) begin
      mn_tens = 3'd3;
      mn_rem  = state.min_count - 6'd30;
    end else if (state.min_count >= 6'd20) begin
      mn_tens = 3'd2;
      mn_rem  = state.min_count - 6'd20;
    end else if (state.min_count >= 6'd10) begin
      mn_tens = 3'd1;
      mn_rem  = state.min_count - 6'd10;
    end else begin
      mn_tens = 3'd0;
      mn_rem  = state.min_count;
    end
  end

  // Edit digits replace the time while editing
  always_comb begin
    if (state.edit_active) begin
      item.hour_tens   = state.edit_digits[0][1:0];
      item.hour_ones   = state.edit_digits[1];
      item.minute_tens = state.edit_digits[2][2:0];
      item.minute_ones = state.edit_digits[3];
    end else begin
      item.hour_tens   = hr_tens;
      item.hour_ones   = hr_rem[3:0];
      item.minute_tens = mn_tens;
      item.minute_ones = mn_rem[3:0];
    end
    item.seconds_now   = state.sec_count;
    item.editing       = state.edit_active;
    item.edit_position = state.digit_select;
    item.blink         = state.blink_bit;
  end

endmodule

@@ hw/rtl/clock_24h_with_digit_editor_core.sv @@
// 24-hour clock with digit editor: input register, state update, result register.
// An accepted item waits in the input register until the result register is free.
// Throughput: one item per cycle while out_ready holds; the input register refills
// while the result register drains, so a stalled result still lets one item wait.
// Reset (rst_n low, synchronous): time 00:00:00, editor off, blink low,
// both stages empty.
module clock_24h_with_digit_editor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ckhm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ckhm_pkg::out_item_t out_item
);

  logic                 in_v_r;
  logic                 in_v_nxt;
  ckhm_pkg::in_item_t   in_item_r;
  logic                 out_v_r;
  logic                 out_v_nxt;
  ckhm_pkg::out_item_t  out_item_r;
  ckhm_pkg::out_item_t  disp_item;
  ckhm_pkg::clk_state_t state_nxt;
  logic                 advance;

  // Stage handshake: the held item moves on when the result slot frees
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_comb begin
    in_v_nxt  = in_ready ? in_valid : in_v_r;
    out_v_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // State update for the held item
  ckhm_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (in_item_r),
    .state_nxt (state_nxt)
  );

  ckhm_disp u_disp (
    .state (state_nxt),
    .item  (disp_item)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= disp_item;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // Checks
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_item_r.seconds_now <= ckhm_pkg::SEC_MAX) &&
                (out_item_r.minute_tens <= 3'd5) && (out_item_r.minute_ones <= 4'd9))
    else $error("result time out of range");

  a_hour_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_item_r.hour_tens == 2'd2) |-> (out_item_r.hour_ones <= 4'd3))
    else $error("hour above 23 shown");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("processed item lost");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ready && !advance) |=> !out_v_r)
    else $error("result item repeated");

endmodule

@@ bench/tb_clock_24h_with_digit_editor_core.sv @@
// Testbench for the 24-hour clock core with digit editor: predicted display checked per item.
`timescale 1ns / 100ps

module tb_clock_24h_with_digit_editor_core;

  localparam logic [2:0] OP_UNUSED    = 3'd7;
  localparam logic [1:0] POS_MIN_ONES = 2'd3;
  localparam int TARGET_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;

  // Tracks the clock and editor state and holds the displays still to come out
  class clock_tracker;
    logic [5:0]          secs;
    logic [5:0]          mins;
    logic [4:0]          hours;
    logic [3:0]          digs [4];
    bit                  editing;
    logic [1:0]          sel;
    bit                  blink;
    ckhm_pkg::out_item_t shown_q [$];
    int                  errors;

    function new();
      secs = '0;
      mins = '0;
      hours = '0;
      foreach (digs[i]) digs[i] = '0;
      editing = 0;
      sel = ckhm_pkg::POS_HOUR_TENS;
      blink = 0;
      errors = 0;
    endfunction

    // Values the selected digit may take; the hour digits limit each other
    function int digit_span(logic [1:0] p);
      case (p)
        ckhm_pkg::POS_HOUR_TENS: return (digs[ckhm_pkg::POS_HOUR_ONES] >= 4) ? 2 : 3;
        ckhm_pkg::POS_HOUR_ONES: return (digs[ckhm_pkg::POS_HOUR_TENS] == 2) ? 4 : 10;
        ckhm_pkg::POS_MIN_TENS:  return 6;
        default:                 return 10;
      endcase
    endfunction

    function void advance_second();
      blink = ~blink;
      if (secs < ckhm_pkg::SEC_MAX) begin
        secs = secs + 1'b1;
      end else begin
        secs = '0;
        if (mins < ckhm_pkg::MIN_MAX) begin
          mins = mins + 1'b1;
        end else begin
          mins = '0;
          hours = (hours < ckhm_pkg::HOUR_MAX) ? hours + 1'b1 : '0;
        end
      end
    endfunction

    // Applies one accepted item; returns 0 when the block ignores it
    function bit note_input(ckhm_pkg::in_item_t it);
      ckhm_pkg::out_item_t e;
      int                  span;
      int                  v;
      bit                  acted;
      acted = 1;
      case (it.opcode)
        ckhm_pkg::OP_TICK: begin
          if (editing) acted = 0;
          else advance_second();
        end
        ckhm_pkg::OP_LOAD: begin
          hours = (it.load_hour > ckhm_pkg::HOUR_MAX) ? ckhm_pkg::HOUR_MAX : it.load_hour;
          mins = (it.load_minute > ckhm_pkg::MIN_MAX) ? ckhm_pkg::MIN_MAX : it.load_minute;
          secs = (it.load_second > ckhm_pkg::SEC_MAX) ? ckhm_pkg::SEC_MAX : it.load_second;
          editing = 0;
        end
        ckhm_pkg::OP_EDIT: begin
          foreach (digs[i]) digs[i] = '0;
          sel = ckhm_pkg::POS_HOUR_TENS;
          editing = 1;
        end
        ckhm_pkg::OP_INC: begin
          if (!editing) begin
            acted = 0;
          end else begin
            span = digit_span(sel);
            digs[sel] = 4'((digs[sel] + 1) % span);
          end
        end
        ckhm_pkg::OP_DEC: begin
          if (!editing) begin
            acted = 0;
          end else begin
            span = digit_span(sel);
            digs[sel] = (digs[sel] == 0) ? 4'(span - 1) : digs[sel] - 1'b1;
          end
        end
        ckhm_pkg::OP_NEXT: begin
          if (!editing) acted = 0;
          else sel = sel + 1'b1;
        end
        ckhm_pkg::OP_ACCEPT: begin
          if (!editing) begin
            acted = 0;
          end else begin
            v = digs[ckhm_pkg::POS_HOUR_TENS] * 10 + digs[ckhm_pkg::POS_HOUR_ONES];
            hours = (v > ckhm_pkg::HOUR_MAX) ? ckhm_pkg::HOUR_MAX : 5'(v);
            v = digs[ckhm_pkg::POS_MIN_TENS] * 10 + digs[POS_MIN_ONES];
            mins = (v > ckhm_pkg::MIN_MAX) ? ckhm_pkg::MIN_MAX : 6'(v);
            secs = '0;
            editing = 0;
          end
        end
        default: acted = 0;
      endcase

      // Display: edit digits while editing, else the time of day
      if (editing) begin
        e.hour_tens   = 2'(digs[ckhm_pkg::POS_HOUR_TENS]);
        e.hour_ones   = digs[ckhm_pkg::POS_HOUR_ONES];
        e.minute_tens = 3'(digs[ckhm_pkg::POS_MIN_TENS]);
        e.minute_ones = digs[POS_MIN_ONES];
      end else begin
        e.hour_tens   = 2'(hours / 10);
        e.hour_ones   = 4'(hours % 10);
        e.minute_tens = 3'(mins / 10);
        e.minute_ones = 4'(mins % 10);
      end
      e.seconds_now   = secs;
      e.editing       = editing;
      e.edit_position = sel;
      e.blink         = blink;
      shown_q.push_back(e);
      return acted;
    endfunction

    function void check_display(ckhm_pkg::out_item_t got);
      ckhm_pkg::out_item_t e;
      string               diffs;
      if (shown_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected display item %h at %0t", got, $realtime);
        return;
      end
      e = shown_q.pop_front();
      diffs = "";
      if (got.hour_tens !== e.hour_tens) diffs = {diffs, " hour_tens"};
      if (got.hour_ones !== e.hour_ones) diffs = {diffs, " hour_ones"};
      if (got.minute_tens !== e.minute_tens) diffs = {diffs, " minute_tens"};
      if (got.minute_ones !== e.minute_ones) diffs = {diffs, " minute_ones"};
      if (got.seconds_now !== e.seconds_now) diffs = {diffs, " seconds_now"};
      if (got.editing !== e.editing) diffs = {diffs, " editing"};
      if (got.edit_position !== e.edit_position) diffs = {diffs, " edit_position"};
      if (got.blink !== e.blink) diffs = {diffs, " blink"};
      if (diffs != "") begin
        errors++;
        if (errors <= 10)
          $display("display mismatch at %0t:%s expected %h got %h", $realtime, diffs, e, got);
      end
    endfunction

    function int pending();
      return shown_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ckhm_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ckhm_pkg::out_item_t out_item;

  clock_tracker tracker = new();
  int useful_items = 0;
  int burst_left = 0;
  int cycles = 0;

  clock_24h_with_digit_editor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_clock_24h_with_digit_editor_core: errors");
      $finish;
    end
  end

  // Result side: check on each handshake, stall in changing modes
  int ready_mode = 0;
  int ready_cnt = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_display(out_item);
    ready_cnt++;
    if (ready_cnt % 48 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (ready_cnt % 5 == 0);
      default: out_ready <= ready_cnt[2];
    endcase
  end

  // Offers one item, waits for it to be taken, then maybe leaves a gap
  task automatic push(input logic [2:0] op, input logic [4:0] h,
                      input logic [5:0] m, input logic [5:0] s);
    ckhm_pkg::in_item_t it;
    int                 gap;
    it.opcode = op;
    it.load_hour = h;
    it.load_minute = m;
    it.load_second = s;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tracker.note_input(it)) useful_items++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Operation with random load fields
  task automatic push_op(input logic [2:0] op);
    push(op, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endtask

  task automatic edit_session();
    int n;
    int r;
    push_op(ckhm_pkg::OP_EDIT);
    n = $urandom_range(1, 14);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) push_op(ckhm_pkg::OP_INC);
      else if (r < 70) push_op(ckhm_pkg::OP_DEC);
      else if (r < 94) push_op(ckhm_pkg::OP_NEXT);
      else if (r < 97) push_op(ckhm_pkg::OP_TICK);
      else push_op(ckhm_pkg::OP_LOAD);
    end
    if ($urandom_range(0, 9) != 0) push_op(ckhm_pkg::OP_ACCEPT);
  endtask

  task automatic tick_run();
    logic [4:0] h;
    logic [5:0] m;
    h = $urandom_range(0, 1) ? ckhm_pkg::HOUR_MAX : 5'($urandom_range(0, 23));
    m = $urandom_range(0, 2) != 0 ? ckhm_pkg::MIN_MAX : 6'($urandom_range(0, 59));
    push(ckhm_pkg::OP_LOAD, h, m, 6'($urandom_range(50, 59)));
    repeat ($urandom_range(1, 12)) push_op(ckhm_pkg::OP_TICK);
  endtask

  // Stimulus
  initial begin
    int r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset state, saturating load, midnight, ignored ops, editor limits
    push(ckhm_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_LOAD, 5'd31, 6'd63, 6'd63);
    push(ckhm_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_LOAD, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_INC, 5'd31, 6'd63, 6'd63);
    push(ckhm_pkg::OP_DEC, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_NEXT, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_ACCEPT, 5'd0, 6'd0, 6'd0);
    push(OP_UNUSED, 5'd31, 6'd63, 6'd63);
    push(ckhm_pkg::OP_EDIT, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_DEC, 5'd0, 6'd0, 6'd0);       // hour tens wraps to 2
    push(ckhm_pkg::OP_NEXT, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_DEC, 5'd0, 6'd0, 6'd0);       // hour ones limited to 0..3
    push(ckhm_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);      // ignored while editing
    push(ckhm_pkg::OP_EDIT, 5'd0, 6'd0, 6'd0);      // restart clears digits
    push(ckhm_pkg::OP_NEXT, 5'd0, 6'd0, 6'd0);
    repeat (4) push(ckhm_pkg::OP_INC, 5'd0, 6'd0, 6'd0);
    repeat (3) push(ckhm_pkg::OP_NEXT, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_DEC, 5'd0, 6'd0, 6'd0);       // hour tens limited to 0..1
    push(ckhm_pkg::OP_NEXT, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_NEXT, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_DEC, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_ACCEPT, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_EDIT, 5'd0, 6'd0, 6'd0);
    push(ckhm_pkg::OP_LOAD, 5'd12, 6'd34, 6'd56);   // load leaves the editor

    // Random: mostly edit sessions and tick runs, with some noise
    useful_items = 0;
    while (useful_items < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) edit_session();
      else if (r < 65) tick_run();
      else if (r < 80) push_op(ckhm_pkg::OP_LOAD);
      else push_op(3'($urandom_range(0, 7)));
    end

    // Drain
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_clock_24h_with_digit_editor_core: clean");
    end else begin
      $display("tb_clock_24h_with_digit_editor_core: errors");
    end
    $finish;
  end

endmodule
